// ----- hdl/assert_macros.svh -----
// Assertion macros used by the port-level checker flha_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define FLHA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define FLHA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/flha_pkg.sv -----
// Shared constants, types and state codes of the free-list heap allocator.
// No dependencies.
package flha_pkg;

    localparam int HEAP_UNITS = 4096;
    localparam int UNIT_BYTES = 16;
    localparam int UB_SHIFT   = $clog2(UNIT_BYTES);
    localparam int AW         = $clog2(HEAP_UNITS + 1);
    localparam int DEPTH      = HEAP_UNITS + 1;
    localparam int WALK_LIMIT = 2 * HEAP_UNITS + 8;
    localparam int SW         = $clog2(WALK_LIMIT + 2);
    localparam int CHUNK_W    = 13;
    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 13'd1024;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic [AW-1:0] need;
        logic          too_big;
    } need_t;

    typedef enum logic [11:0] {
        ST_CLEAR   = 12'b000000000001,
        ST_IDLE    = 12'b000000000010,
        ST_NEED    = 12'b000000000100,
        ST_A_LINK  = 12'b000000001000,
        ST_A_SIZE  = 12'b000000010000,
        ST_A_SPLIT = 12'b000000100000,
        ST_GROW    = 12'b000001000000,
        ST_R_CHK   = 12'b000010000000,
        ST_R_SIZE  = 12'b000100000000,
        ST_R_WALK  = 12'b001000000000,
        ST_R_NEXT  = 12'b010000000000,
        ST_R_PREV  = 12'b100000000000
    } state_t;

endpackage

// ----- hdl/free_list_heap_allocator.sv -----
// Top level of the next-fit free-list heap allocator with coalescing.
// Depends on flha_pkg, flha_ram and flha_need.
//
// One request at a time; each request gives one result. Headers live in two
// RAMs (links and sizes), and every step of a list walk is one read of them.
// A heap growth adds a full free walk to an allocate. After reset a clearing
// pass zeroes all 4097 header entries; no request is taken during it, while
// chunk_units writes are.
module free_list_heap_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    // request: element_count[15:0], element_size[31:16], block_address[44:32]
    input  logic [47:0] s_tdata,
    // request: kind
    input  logic        s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // result: granted_address[12:0]
    output logic [15:0] m_tdata,
    // result: failed
    output logic        m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic [12:0] cfg_data,
    input  logic        cfg_valid,
    output logic        cfg_ready
);

    localparam int AW = flha_pkg::AW;
    localparam logic [AW-1:0] LAST_ENTRY = AW'(flha_pkg::HEAP_UNITS);
    localparam logic [flha_pkg::SW-1:0] STEP_MAX = flha_pkg::SW'(flha_pkg::WALK_LIMIT);

    flha_pkg::state_t state_reg, state_next;
    logic [AW-1:0] rov_reg, rov_next;
    logic [AW-1:0] brk_reg, brk_next;
    logic [flha_pkg::CHUNK_W-1:0] chunk_reg;
    logic [AW-1:0] p_reg, p_next;
    logic [AW-1:0] prev_reg, prev_next;
    logic [AW-1:0] n_reg, n_next;
    logic [AW-1:0] bp_reg, bp_next;
    logic [AW-1:0] sz_reg, sz_next;
    logic [AW-1:0] bsz_reg, bsz_next;
    logic [AW-1:0] blink_reg, blink_next;
    logic [flha_pkg::SW-1:0] ast_reg, ast_next;
    logic [flha_pkg::SW-1:0] rst_reg, rst_next;
    logic grow_reg, grow_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic out_valid_reg, out_valid_next;
    logic [AW-1:0] out_addr_reg, out_addr_next;
    logic out_fail_reg, out_fail_next;

    logic [AW-1:0] raddr;
    logic [AW-1:0] link_q, size_q;
    logic link_we, size_we;
    logic [AW-1:0] link_waddr, link_wdata, size_waddr, size_wdata;

    flha_pkg::need_t need_info;
    logic accept;
    logic [12:0] req_addr;
    logic rel_done, rel_ok;
    logic found;
    logic [AW:0] sum_w;
    logic [AW:0] grow_end;
    logic [AW-1:0] nu;
    logic [AW-1:0] split_at;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == flha_pkg::ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign req_addr  = s_tdata[44:32];
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'b000, out_addr_reg};
    assign m_tuser   = out_fail_reg;

    flha_need u_need (
        .aclk          (aclk),
        .load          (accept),
        .element_count (s_tdata[15:0]),
        .element_size  (s_tdata[31:16]),
        .need_out      (need_info)
    );

    flha_ram #(.WIDTH(AW), .DEPTH(flha_pkg::DEPTH)) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (raddr),
        .rdata (link_q)
    );

    flha_ram #(.WIDTH(AW), .DEPTH(flha_pkg::DEPTH)) u_size_ram (
        .aclk  (aclk),
        .we    (size_we),
        .waddr (size_waddr),
        .wdata (size_wdata),
        .raddr (raddr),
        .rdata (size_q)
    );

    always_comb begin
        state_next     = state_reg;
        rov_next       = rov_reg;
        brk_next       = brk_reg;
        p_next         = p_reg;
        prev_next      = prev_reg;
        n_next         = n_reg;
        bp_next        = bp_reg;
        sz_next        = sz_reg;
        bsz_next       = bsz_reg;
        blink_next     = blink_reg;
        ast_next       = ast_reg;
        rst_next       = rst_reg;
        grow_next      = grow_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_addr_next  = out_addr_reg;
        out_fail_next  = out_fail_reg;
        raddr          = '0;
        link_we        = 1'b0;
        link_waddr     = '0;
        link_wdata     = '0;
        size_we        = 1'b0;
        size_waddr     = '0;
        size_wdata     = '0;
        rel_done       = 1'b0;
        rel_ok         = 1'b0;
        found          = 1'b0;
        sum_w          = '0;
        grow_end       = '0;
        nu             = '0;
        split_at       = '0;

        case (state_reg)
            flha_pkg::ST_CLEAR: begin
                link_we    = 1'b1;
                link_waddr = clr_reg;
                size_we    = 1'b1;
                size_waddr = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == LAST_ENTRY) begin
                    state_next = flha_pkg::ST_IDLE;
                end
            end
            flha_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == flha_pkg::KIND_FREE) begin
                        if (req_addr == 13'd0) begin
                            out_valid_next = 1'b1;
                            out_addr_next  = '0;
                            out_fail_next  = 1'b0;
                        end else begin
                            bp_next    = AW'(req_addr - 13'd1);
                            grow_next  = 1'b0;
                            state_next = flha_pkg::ST_R_CHK;
                        end
                    end else begin
                        state_next = flha_pkg::ST_NEED;
                    end
                end
            end
            flha_pkg::ST_NEED: begin
                if (need_info.too_big) begin
                    out_valid_next = 1'b1;
                    out_addr_next  = '0;
                    out_fail_next  = 1'b1;
                    state_next     = flha_pkg::ST_IDLE;
                end else begin
                    prev_next  = rov_reg;
                    ast_next   = '0;
                    raddr      = rov_reg;
                    state_next = flha_pkg::ST_A_LINK;
                end
            end
            flha_pkg::ST_A_LINK: begin
                p_next     = link_q;
                raddr      = link_q;
                state_next = flha_pkg::ST_A_SIZE;
            end
            flha_pkg::ST_A_SIZE: begin
                if (size_q >= need_info.need) begin
                    rov_next = prev_reg;
                    if (size_q == need_info.need) begin
                        link_we        = 1'b1;
                        link_waddr     = prev_reg;
                        link_wdata     = link_q;
                        out_valid_next = 1'b1;
                        out_addr_next  = p_reg + 1'b1;
                        out_fail_next  = 1'b0;
                        state_next     = flha_pkg::ST_IDLE;
                    end else begin
                        split_at   = p_reg + (size_q - need_info.need);
                        size_we    = 1'b1;
                        size_waddr = p_reg;
                        size_wdata = size_q - need_info.need;
                        p_next     = split_at;
                        state_next = flha_pkg::ST_A_SPLIT;
                    end
                end else if (p_reg == rov_reg) begin
                    state_next = flha_pkg::ST_GROW;
                end else if (ast_reg >= STEP_MAX) begin
                    out_valid_next = 1'b1;
                    out_addr_next  = '0;
                    out_fail_next  = 1'b1;
                    state_next     = flha_pkg::ST_IDLE;
                end else begin
                    ast_next  = ast_reg + 1'b1;
                    prev_next = p_reg;
                    p_next    = link_q;
                    raddr     = link_q;
                end
            end
            flha_pkg::ST_A_SPLIT: begin
                size_we        = 1'b1;
                size_waddr     = p_reg;
                size_wdata     = need_info.need;
                out_valid_next = 1'b1;
                out_addr_next  = p_reg + 1'b1;
                out_fail_next  = 1'b0;
                state_next     = flha_pkg::ST_IDLE;
            end
            flha_pkg::ST_GROW: begin
                nu       = (need_info.need < AW'(chunk_reg)) ? AW'(chunk_reg)
                                                            : need_info.need;
                grow_end = {1'b0, brk_reg} - 1'b1 + {1'b0, nu};
                if (grow_end > (AW+1)'(flha_pkg::HEAP_UNITS)) begin
                    out_valid_next = 1'b1;
                    out_addr_next  = '0;
                    out_fail_next  = 1'b1;
                    state_next     = flha_pkg::ST_IDLE;
                end else begin
                    size_we    = 1'b1;
                    size_waddr = brk_reg;
                    size_wdata = nu;
                    link_we    = 1'b1;
                    link_waddr = brk_reg;
                    link_wdata = '0;
                    brk_next   = brk_reg + nu;
                    bp_next    = brk_reg;
                    grow_next  = 1'b1;
                    state_next = flha_pkg::ST_R_CHK;
                end
            end
            flha_pkg::ST_R_CHK: begin
                if (bp_reg == '0 || bp_reg >= brk_reg) begin
                    rel_done = 1'b1;
                end else begin
                    raddr      = bp_reg;
                    state_next = flha_pkg::ST_R_SIZE;
                end
            end
            flha_pkg::ST_R_SIZE: begin
                sum_w = {1'b0, bp_reg} + {1'b0, size_q};
                if (size_q == '0 || sum_w > {1'b0, brk_reg}) begin
                    rel_done = 1'b1;
                end else begin
                    sz_next    = size_q;
                    p_next     = rov_reg;
                    rst_next   = '0;
                    raddr      = rov_reg;
                    state_next = flha_pkg::ST_R_WALK;
                end
            end
            flha_pkg::ST_R_WALK: begin
                found = (bp_reg > p_reg && bp_reg < link_q)
                     || (p_reg >= link_q && (bp_reg > p_reg || bp_reg < link_q));
                if (found) begin
                    n_next     = link_q;
                    raddr      = link_q;
                    state_next = flha_pkg::ST_R_NEXT;
                end else if (rst_reg >= STEP_MAX) begin
                    rel_done = 1'b1;
                end else begin
                    rst_next = rst_reg + 1'b1;
                    p_next   = link_q;
                    raddr    = link_q;
                end
            end
            flha_pkg::ST_R_NEXT: begin
                sum_w      = {1'b0, bp_reg} + {1'b0, sz_reg};
                link_we    = 1'b1;
                link_waddr = bp_reg;
                if (sum_w == {1'b0, n_reg}) begin
                    size_we    = 1'b1;
                    size_waddr = bp_reg;
                    size_wdata = sz_reg + size_q;
                    link_wdata = link_q;
                    bsz_next   = sz_reg + size_q;
                    blink_next = link_q;
                end else begin
                    link_wdata = n_reg;
                    bsz_next   = sz_reg;
                    blink_next = n_reg;
                end
                raddr      = p_reg;
                state_next = flha_pkg::ST_R_PREV;
            end
            flha_pkg::ST_R_PREV: begin
                sum_w      = {1'b0, p_reg} + {1'b0, size_q};
                link_we    = 1'b1;
                link_waddr = p_reg;
                if (sum_w == {1'b0, bp_reg}) begin
                    size_we    = 1'b1;
                    size_waddr = p_reg;
                    size_wdata = size_q + bsz_reg;
                    link_wdata = blink_reg;
                end else begin
                    link_wdata = bp_reg;
                end
                rov_next = p_reg;
                rel_done = 1'b1;
                rel_ok   = 1'b1;
            end
            default: begin
                state_next = flha_pkg::ST_IDLE;
            end
        endcase

        if (rel_done) begin
            if (!grow_reg) begin
                out_valid_next = 1'b1;
                out_addr_next  = '0;
                out_fail_next  = 1'b0;
                state_next     = flha_pkg::ST_IDLE;
            end else if (!rel_ok || ast_reg >= STEP_MAX) begin
                out_valid_next = 1'b1;
                out_addr_next  = '0;
                out_fail_next  = 1'b1;
                state_next     = flha_pkg::ST_IDLE;
            end else begin
                // forward the link being written to the new rover
                ast_next   = ast_reg + 1'b1;
                prev_next  = p_reg;
                p_next     = link_wdata;
                raddr      = link_wdata;
                state_next = flha_pkg::ST_A_SIZE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= flha_pkg::ST_CLEAR;
            rov_reg       <= '0;
            brk_reg       <= AW'(1);
            chunk_reg     <= flha_pkg::CHUNK_RESET;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            grow_reg      <= 1'b0;
            ast_reg       <= '0;
            rst_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            rov_reg       <= rov_next;
            brk_reg       <= brk_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            grow_reg      <= grow_next;
            ast_reg       <= ast_next;
            rst_reg       <= rst_next;
            if (cfg_valid && cfg_ready) begin
                chunk_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        p_reg        <= p_next;
        prev_reg     <= prev_next;
        n_reg        <= n_next;
        bp_reg       <= bp_next;
        sz_reg       <= sz_next;
        bsz_reg      <= bsz_next;
        blink_reg    <= blink_next;
        out_addr_reg <= out_addr_next;
        out_fail_reg <= out_fail_next;
    end

endmodule

// ----- hdl/flha_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module flha_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4097
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/flha_need.sv -----
// Request sizing: registered byte product, rounded up to units plus one header.
// Depends on flha_pkg.
module flha_need (
    input  logic                 aclk,
    input  logic                 load,
    input  logic [15:0]          element_count,
    input  logic [15:0]          element_size,
    output flha_pkg::need_t      need_out
);

    logic [31:0] prod_reg;
    logic [32:0] sum;
    logic [32:0] units;
    logic [32:0] need_full;

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= element_count * element_size;
        end
    end

    always_comb begin
        sum       = {1'b0, prod_reg} + 33'(flha_pkg::UNIT_BYTES - 1);
        units     = sum >> flha_pkg::UB_SHIFT;
        need_full = units + 33'd1;
        need_out.too_big = need_full > 33'(flha_pkg::HEAP_UNITS);
        need_out.need    = need_full[flha_pkg::AW-1:0];
    end

endmodule

// ----- hdl/flha_checker.sv -----
// Port-level checks of the free-list heap allocator, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module flha_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tvalid,
    input logic        m_tready
);

    `FLHA_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
    `FLHA_ASSERT(a_fail_zero, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata == 16'd0, "failed result carries an address")
    `FLHA_ASSERT(a_no_overrun, aclk, aresetn, s_tready |-> !m_tvalid || m_tready, "request taken while result blocked")
    `FLHA_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid && !s_tready, "busy right after reset")

endmodule

bind free_list_heap_allocator flha_checker u_flha_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ----- dv/free_list_heap_allocator_checker.sv -----
// Checker for the free-list heap allocator: watches the request, result and
// chunk_units channels, predicts each result and compares it field by field.
// Depends on flha_pkg.
`timescale 1ns / 100ps

module free_list_heap_allocator_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [47:0] s_tdata,
    input  logic        s_tuser,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [12:0] cfg_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    output int          errors,
    output int          outstanding
);

    typedef struct {
        logic [12:0] addr;
        logic        fail;
    } grant_t;

    grant_t           grant_q[$];
    int unsigned      heap_link[0:flha_pkg::HEAP_UNITS];
    int unsigned      heap_size[0:flha_pkg::HEAP_UNITS];
    int unsigned      rover;
    int unsigned      brk;
    int unsigned      chunk;

    initial begin
        errors = 0;
        outstanding = 0;
    end

    function automatic int unsigned rd_link(int unsigned i);
        return (i <= flha_pkg::HEAP_UNITS) ? heap_link[i] : 0;
    endfunction

    function automatic int unsigned rd_size(int unsigned i);
        return (i <= flha_pkg::HEAP_UNITS) ? heap_size[i] : 0;
    endfunction

    function automatic void wr_link(int unsigned i, int unsigned v);
        if (i <= flha_pkg::HEAP_UNITS) heap_link[i] = v;
    endfunction

    function automatic void wr_size(int unsigned i, int unsigned v);
        if (i <= flha_pkg::HEAP_UNITS) heap_size[i] = v;
    endfunction

    function automatic bit try_release(int unsigned bp);
        int unsigned p, n, sz, steps;
        p = rover;
        steps = 0;
        if (bp < 1 || bp >= brk) return 0;
        sz = rd_size(bp);
        if (sz == 0 || longint'(bp) + sz > longint'(brk)) return 0;
        forever begin
            n = rd_link(p);
            if (bp > p && bp < n) break;
            if (p >= n && (bp > p || bp < n)) break;
            steps++;
            if (steps > flha_pkg::WALK_LIMIT) return 0;
            p = n;
        end
        if (bp + sz == n) begin
            wr_size(bp, sz + rd_size(n));
            wr_link(bp, rd_link(n));
        end else begin
            wr_link(bp, n);
        end
        if (longint'(p) + rd_size(p) == longint'(bp)) begin
            wr_size(p, rd_size(p) + rd_size(bp));
            wr_link(p, rd_link(bp));
        end else begin
            wr_link(p, bp);
        end
        rover = p;
        return 1;
    endfunction

    function automatic bit try_grow(int unsigned need);
        int unsigned nu, at;
        nu = (need < chunk) ? chunk : need;
        at = brk;
        if (longint'(at) - 1 + nu > flha_pkg::HEAP_UNITS) return 0;
        wr_size(at, nu);
        wr_link(at, 0);
        brk = at + nu;
        return try_release(at);
    endfunction

    function automatic int unsigned try_carve(int unsigned need);
        int unsigned prev, p, sz, steps;
        prev = rover;
        steps = 0;
        p = rd_link(prev);
        forever begin
            sz = rd_size(p);
            if (sz >= need) begin
                if (sz == need) begin
                    wr_link(prev, rd_link(p));
                end else begin
                    wr_size(p, sz - need);
                    p += sz - need;
                    wr_size(p, need);
                end
                rover = prev;
                return p + 1;
            end
            if (p == rover) begin
                if (!try_grow(need)) return 0;
                p = rover;
            end
            steps++;
            if (steps > flha_pkg::WALK_LIMIT) return 0;
            prev = p;
            p = rd_link(p);
        end
    endfunction

    function automatic grant_t predict_grant(logic kind, logic [15:0] cnt, logic [15:0] esz,
                                             logic [12:0] addr);
        grant_t      g;
        longint      bytes, need;
        int unsigned got;
        g.addr = '0;
        g.fail = 1'b0;
        if (kind == flha_pkg::KIND_FREE) begin
            if (addr >= 1) void'(try_release(addr - 1));
        end else begin
            bytes = longint'(cnt) * longint'(esz);
            need = (bytes + flha_pkg::UNIT_BYTES - 1) / flha_pkg::UNIT_BYTES + 1;
            got = 0;
            if (need <= flha_pkg::HEAP_UNITS) got = try_carve(int'(need));
            if (got == 0) g.fail = 1'b1;
            else g.addr = got[12:0];
        end
        return g;
    endfunction

    task automatic report(string what);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    always @(posedge aclk) begin
        grant_t g;
        if (!aresetn) begin
            for (int i = 0; i <= flha_pkg::HEAP_UNITS; i++) begin
                heap_link[i] = 0;
                heap_size[i] = 0;
            end
            rover = 0;
            brk = 1;
            chunk = flha_pkg::CHUNK_RESET;
            grant_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) chunk = cfg_data;
            if (m_tvalid && m_tready) begin
                if (grant_q.size() == 0) begin
                    report($sformatf("unexpected result addr=%0d failed=%0b",
                                     m_tdata[12:0], m_tuser));
                end else begin
                    g = grant_q.pop_front();
                    if (m_tdata[12:0] !== g.addr)
                        report($sformatf("granted_address %0d, want %0d",
                                         m_tdata[12:0], g.addr));
                    if (m_tuser !== g.fail)
                        report($sformatf("failed %0b, want %0b", m_tuser, g.fail));
                end
            end
            if (s_tvalid && s_tready)
                grant_q.push_back(predict_grant(s_tuser, s_tdata[15:0], s_tdata[31:16],
                                                s_tdata[44:32]));
        end
        outstanding = grant_q.size();
    end

endmodule

// ----- dv/free_list_heap_allocator_test.sv -----
// Top of the heap allocator testbench: clock, reset, request and chunk_units
// stimulus, result back-pressure and the verdict.
// Depends on flha_pkg, free_list_heap_allocator and its checker.
`timescale 1ns / 100ps

module free_list_heap_allocator_test;

    logic        aclk;
    logic        aresetn;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [12:0] cfg_data;
    logic        cfg_valid;
    logic        cfg_ready;
    int          errors;
    int          outstanding;

    int          send_gap_pct;
    int          stall_pct;
    int          hold_asks;
    int          hold_done;
    int          hold_left;
    logic        sent_kind_q[$];
    logic [12:0] live_q[$];

    free_list_heap_allocator dut (.*);

    free_list_heap_allocator_checker checker_i (.*);

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // back-pressure on results
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left <= 0;
            hold_done <= 0;
        end else if (hold_asks != hold_done) begin
            hold_done <= hold_done + 1;
            hold_left <= 400;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // track live grants so frees stay mostly well formed
    always @(posedge aclk) begin
        logic k;
        if (aresetn && m_tvalid && m_tready && sent_kind_q.size() > 0) begin
            k = sent_kind_q.pop_front();
            if (k == flha_pkg::KIND_ALLOC && !m_tuser) live_q.push_back(m_tdata[12:0]);
        end
    end

    task automatic send_req(logic kind, logic [15:0] cnt, logic [15:0] esz, logic [12:0] addr);
        if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tdata <= {3'b000, addr, esz, cnt};
        s_tuser <= kind;
        s_tvalid <= 1'b1;
        forever begin
            @(negedge aclk);
            if (s_tready) break;
        end
        @(posedge aclk);
        sent_kind_q.push_back(kind);
    endtask

    task automatic idle_tx();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        idle_tx();
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_chunk(logic [12:0] v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        forever begin
            @(negedge aclk);
            if (cfg_ready) break;
        end
        @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic free_live();
        int          i;
        logic [12:0] a;
        i = $urandom_range(live_q.size() - 1);
        a = live_q[i];
        live_q.delete(i);
        send_req(flha_pkg::KIND_FREE, 16'($urandom), 16'($urandom), a);
    endtask

    task automatic random_req(bit noisy);
        int          r;
        logic [12:0] a;
        r = $urandom_range(99);
        if (live_q.size() > 0 && r < 45) begin
            free_live();
        end else if (noisy && r >= 97) begin
            a = 13'($urandom);
            if (a == 0 || a > 4097)
                send_req(flha_pkg::KIND_FREE, 16'($urandom), 16'($urandom), a);
            else send_req(flha_pkg::KIND_FREE, 16'($urandom), 16'($urandom), 13'd0);
        end else if (r >= 94) begin
            send_req(flha_pkg::KIND_ALLOC, 16'($urandom), 16'($urandom), 13'($urandom));
        end else if (r >= 88) begin
            send_req(flha_pkg::KIND_ALLOC, 16'($urandom_range(1, 256)),
                     16'($urandom_range(16, 256)), 13'($urandom));
        end else begin
            send_req(flha_pkg::KIND_ALLOC, 16'($urandom_range(0, 8)),
                     16'($urandom_range(0, 64)), 13'($urandom));
        end
    endtask

    task automatic run_phase(int gap, int stall, int n, bit noisy);
        send_gap_pct = gap;
        stall_pct = stall;
        repeat (n) random_req(noisy);
        drain();
    endtask

    initial begin
        logic [12:0] first;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser <= 1'b0;
        s_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        hold_asks = 0;
        send_gap_pct = 0;
        stall_pct = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_chunk(13'd4096);

        // directed: edge sizes, too-large, exhaustion, bad frees, coalescing
        send_req(flha_pkg::KIND_ALLOC, 16'd0, 16'd0, 13'd0);
        send_req(flha_pkg::KIND_ALLOC, 16'd1, 16'd1, 13'h1FFF);
        send_req(flha_pkg::KIND_ALLOC, 16'hFFFF, 16'hFFFF, 13'd0);
        send_req(flha_pkg::KIND_ALLOC, 16'hFFFF, 16'd0, 13'd0);
        send_req(flha_pkg::KIND_ALLOC, 16'd0, 16'hFFFF, 13'd0);
        send_req(flha_pkg::KIND_ALLOC, 16'd256, 16'd16, 13'd0);
        send_req(flha_pkg::KIND_ALLOC, 16'd4000, 16'd16, 13'd0);
        send_req(flha_pkg::KIND_FREE, 16'hFFFF, 16'hFFFF, 13'd0);
        send_req(flha_pkg::KIND_FREE, 16'd0, 16'd0, 13'h1FFF);
        send_req(flha_pkg::KIND_FREE, 16'd0, 16'd0, 13'd4096);
        send_req(flha_pkg::KIND_FREE, 16'd0, 16'd0, 13'd4097);
        drain();
        while (live_q.size() > 0) free_live();
        drain();
        write_chunk(13'd1);
        send_req(flha_pkg::KIND_ALLOC, 16'd1, 16'd16, 13'd0);
        send_req(flha_pkg::KIND_ALLOC, 16'd1, 16'd16, 13'd0);
        send_req(flha_pkg::KIND_ALLOC, 16'd1, 16'd16, 13'd0);
        drain();
        first = live_q[0];
        send_req(flha_pkg::KIND_FREE, 16'd0, 16'd0, live_q[2]);
        send_req(flha_pkg::KIND_FREE, 16'd0, 16'd0, first);
        send_req(flha_pkg::KIND_FREE, 16'd0, 16'd0, live_q[1]);
        live_q.delete();
        send_req(flha_pkg::KIND_ALLOC, 16'd4095, 16'd16, 13'd0);
        drain();

        run_phase(0, 0, 260, 1'b0);
        write_chunk(13'd1024);
        run_phase(56, 0, 260, 1'b0);
        write_chunk(13'd37);
        run_phase(0, 56, 260, 1'b1);
        write_chunk(13'd4096);
        send_gap_pct = 0;
        stall_pct = 0;
        hold_asks = hold_asks + 1;
        repeat (40) random_req(1'b0);
        run_phase(28, 28, 220, 1'b1);
        write_chunk(13'd1);
        run_phase(0, 0, 260, 1'b1);

        // double free last, since it may corrupt the list
        if (live_q.size() > 0) begin
            first = live_q[0];
            send_req(flha_pkg::KIND_FREE, 16'd0, 16'd0, first);
            send_req(flha_pkg::KIND_FREE, 16'd0, 16'd0, first);
            send_req(flha_pkg::KIND_ALLOC, 16'd2, 16'd8, 13'd0);
        end
        drain();
        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
